>>> hw/rtl/tcce_pkg.sv
package tcce_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths fixed by the stream payload.
    localparam int CHAR_W     = 8;
    localparam int ROW_PORT_W = 5;
    localparam int COL_PORT_W = 7;
    localparam int CELL_W     = 16;
    localparam int MODE_W     = 2;

    // Character and attribute constants.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h0F;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified operation handed to the back part.
    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_WRITE     = 3'd1,
        OP_NEWLINE   = 3'd2,
        OP_BACKSPACE = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CHAR_W-1:0]     ch;
        logic [ROW_PORT_W-1:0] rd_row;
        logic [COL_PORT_W-1:0] rd_col;
        logic                  rd_ok;
    } cmd_t;

endpackage

>>> hw/rtl/tcce_ram.sv
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tcce_front.sv
module tcce_front #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // char_code, read_row, read_col
    input  logic [tcce_pkg::MODE_W-1:0]   s_tuser,  // mode
    output logic                          cmd_valid,
    output tcce_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    tcce_pkg::cmd_t                    cls_cmd;
    tcce_pkg::cmd_t                    q_reg [tcce_pkg::QUEUE_DEPTH];
    logic [tcce_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [tcce_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [tcce_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [tcce_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [tcce_pkg::QCNT_W-1:0]       count_reg;
    logic [tcce_pkg::QCNT_W-1:0]       count_next;
    logic                              push;
    logic                              pop;

    // Unpack the incoming word and classify it.
    always_comb
    begin
        cls_cmd.ch     = s_tdata[7:0];
        cls_cmd.rd_row = s_tdata[12:8];
        cls_cmd.rd_col = s_tdata[19:13];
        cls_cmd.rd_ok  = (32'(s_tdata[12:8]) < 32'(ROWS)) &&
                         (32'(s_tdata[19:13]) < 32'(COLUMNS));
        case (s_tuser)
            tcce_pkg::MODE_PUT:
            begin
                if (s_tdata[7:0] == tcce_pkg::CH_NEWLINE)
                begin
                    cls_cmd.op = tcce_pkg::OP_NEWLINE;
                end
                else if (s_tdata[7:0] == tcce_pkg::CH_BACKSPACE)
                begin
                    cls_cmd.op = tcce_pkg::OP_BACKSPACE;
                end
                else
                begin
                    cls_cmd.op = tcce_pkg::OP_WRITE;
                end
            end
            tcce_pkg::MODE_CLEAR:
            begin
                cls_cmd.op = tcce_pkg::OP_CLEAR;
            end
            tcce_pkg::MODE_READ:
            begin
                cls_cmd.op = tcce_pkg::OP_READ;
            end
            default:
            begin
                cls_cmd.op = tcce_pkg::OP_NOP;
            end
        endcase
    end

    // Queue handshake.
    assign s_tready  = (count_reg != tcce_pkg::QCNT_W'(tcce_pkg::QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tcce_pkg::QPTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tcce_pkg::QPTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

>>> hw/rtl/tcce_back.sv
module tcce_back #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tcce_pkg::CHAR_W-1:0]   cfg_wr_data,
    input  logic                          cmd_valid,
    input  tcce_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,  // echo byte, cursor row,
                                                    // cursor column, cell value
    output logic [0:0]                    m_tuser   // echo_valid
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ROW_SW = ROW_W + 1;

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_READ  = 4'b1000
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [tcce_pkg::CHAR_W-1:0]        attr_reg;
    logic [ROW_W-1:0]                   row_reg;
    logic [ROW_W-1:0]                   row_next;
    logic [COL_W-1:0]                   col_reg;
    logic [COL_W-1:0]                   col_next;
    logic [ROW_W-1:0]                   base_reg;
    logic [ROW_W-1:0]                   base_next;
    logic [ADDR_W-1:0]                  sweep_addr_reg;
    logic [ADDR_W-1:0]                  sweep_addr_next;
    logic [ADDR_W-1:0]                  sweep_end_reg;
    logic [ADDR_W-1:0]                  sweep_end_next;
    logic [tcce_pkg::CELL_W-1:0]        sweep_data_reg;
    logic [tcce_pkg::CELL_W-1:0]        sweep_data_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               echo_v_reg;
    logic                               echo_v_next;
    logic [tcce_pkg::CHAR_W-1:0]        echo_b_reg;
    logic [tcce_pkg::CHAR_W-1:0]        echo_b_next;
    logic [tcce_pkg::CELL_W-1:0]        cell_reg;
    logic [tcce_pkg::CELL_W-1:0]        cell_next;
    logic                               out_free;
    logic                               newline_c;
    logic [tcce_pkg::CELL_W-1:0]        blank_c;
    logic [ADDR_W-1:0]                  scroll_start_c;
    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]        ram_wdata;
    logic                               ram_re;
    logic [ADDR_W-1:0]                  ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]        ram_rdata;

    // Screen store; rows are kept as a ring whose top row is base_reg.
    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Map a screen row and column to a store address through the ring base.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [ROW_W-1:0] b,
        input logic [COL_W-1:0] c
    );
        logic [ROW_SW-1:0] sum;
        logic [ROW_SW-1:0] phys;
        sum  = {1'b0, r} + {1'b0, b};
        phys = (sum >= ROW_SW'(ROWS)) ? sum - ROW_SW'(ROWS) : sum;
        return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    assign out_free       = !out_valid_reg || m_tready;
    assign blank_c        = {attr_reg, tcce_pkg::CH_SPACE};
    assign scroll_start_c = ADDR_W'(base_reg) * ADDR_W'(COLUMNS);

    // Command sequencer.
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        sweep_data_next = sweep_data_reg;
        out_valid_next  = out_valid_reg;
        echo_v_next     = echo_v_reg;
        echo_b_next     = echo_b_reg;
        cell_next       = cell_reg;
        cmd_pop         = 1'b0;
        newline_c       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = {tcce_pkg::ATTR_RESET, tcce_pkg::CH_SPACE};
                if (sweep_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = sweep_data_reg;
                if (sweep_addr_reg == sweep_end_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                echo_v_next    = 1'b0;
                echo_b_next    = '0;
                cell_next      = ram_rdata;
                state_next     = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    echo_v_next    = 1'b0;
                    echo_b_next    = '0;
                    cell_next      = '0;
                    case (cmd.op)
                        tcce_pkg::OP_WRITE:
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = cell_addr(row_reg, base_reg, col_reg);
                            ram_wdata   = {attr_reg, cmd.ch};
                            echo_v_next = 1'b1;
                            echo_b_next = cmd.ch;
                            if (col_reg == COL_W'(COLUMNS - 1))
                            begin
                                newline_c = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        tcce_pkg::OP_NEWLINE:
                        begin
                            echo_v_next = 1'b1;
                            echo_b_next = cmd.ch;
                            newline_c   = 1'b1;
                        end
                        tcce_pkg::OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next  = col_reg - 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(row_reg, base_reg, col_reg - 1'b1);
                                ram_wdata = blank_c;
                            end
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            row_next        = '0;
                            col_next        = '0;
                            base_next       = '0;
                            sweep_addr_next = '0;
                            sweep_end_next  = ADDR_W'(CELLS - 1);
                            sweep_data_next = blank_c;
                            state_next      = S_SWEEP;
                        end
                        tcce_pkg::OP_READ:
                        begin
                            if (cmd.rd_ok)
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = cell_addr(ROW_W'(cmd.rd_row), base_reg,
                                                           COL_W'(cmd.rd_col));
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            cell_next = '0;
                        end
                    endcase

                    // Line feed: past the last row the ring turns and the old
                    // top row is blanked as the new bottom row.
                    if (newline_c)
                    begin
                        col_next = '0;
                        if (row_reg == ROW_W'(ROWS - 1))
                        begin
                            base_next       = (base_reg == ROW_W'(ROWS - 1)) ?
                                              '0 : base_reg + 1'b1;
                            sweep_addr_next = scroll_start_c;
                            sweep_end_next  = scroll_start_c + ADDR_W'(COLUMNS - 1);
                            sweep_data_next = blank_c;
                            state_next      = S_SWEEP;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            attr_reg       <= tcce_pkg::ATTR_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sweep_data_reg <= sweep_data_next;
        echo_v_reg     <= echo_v_next;
        echo_b_reg     <= echo_b_next;
        cell_reg       <= cell_next;
    end

    // The cursor only moves when a new command is taken, which needs the
    // output word to be gone, so it can drive the output directly.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = echo_v_reg;
    assign m_tdata  = {4'b0, cell_reg, tcce_pkg::COL_PORT_W'(col_reg),
                       tcce_pkg::ROW_PORT_W'(row_reg), echo_b_reg};

endmodule

>>> hw/rtl/text_console_cursor_engine.sv
// Results: an accepted word is queued, then its result word is registered; a cell read
// also passes through the registered store read. Throughput: one word a cycle while
// the result side keeps up; a cell read holds the back part for its store read, a
// scroll while the new bottom row is blanked and a clear while every cell is blanked.
// Reset: asynchronous, active low; afterwards a blanking pass writes every cell
// (COLUMNS*ROWS cells, 2000 by default) before the back part takes the first word.
module text_console_cursor_engine #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tcce_pkg::CHAR_W-1:0]   cfg_wr_data,  // text_attribute
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,      // char_code, read_row, read_col
    input  logic [tcce_pkg::MODE_W-1:0]   s_tuser,      // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,      // echo byte, cursor row,
                                                        // cursor column, cell value
    output logic [0:0]                    m_tuser       // echo_valid
);

    logic           cmd_valid;
    logic           cmd_pop;
    tcce_pkg::cmd_t cmd;

    // Front part: accept, classify and queue.
    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back part: cursor, screen store and result word.
    tcce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
